// File: rtl/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types, constants and the Morse look-up for the key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

    localparam int MAX_SYMBOLS    = 6;
    localparam int TIMER_BITS     = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CNT_BITS       = $clog2(MAX_SYMBOLS + 1);
    localparam int CMP_BITS       = (TIMER_BITS > CFG_DATA_BITS) ? TIMER_BITS : CFG_DATA_BITS;
    localparam int CODE_BITS      = 7;
    localparam int TABLE_LEN      = 36;

    localparam logic [CFG_DATA_BITS-1:0] DASH_THR_RESET = CFG_DATA_BITS'(200);
    localparam logic [CFG_DATA_BITS-1:0] LETTER_GAP_RESET = CFG_DATA_BITS'(500);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DASH_THRESHOLD = 1'b0,
        CFG_LETTER_GAP     = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SYM_NONE = 2'd0,
        SYM_DOT  = 2'd1,
        SYM_DASH = 2'd2
    } t_sym;

    // timing stage -> symbol store
    typedef struct packed {
        logic held;
        t_sym sym;
        logic gap_hit;
    } t_key_evt;

    // symbol store -> result register
    typedef struct packed {
        logic                 ready;
        logic                 invalid;
        logic [CODE_BITS-1:0] code;
    } t_letter;

    // len = symbol count, pat bit i set = symbol i is a dash
    typedef struct packed {
        logic [2:0]           len;
        logic [4:0]           pat;
        logic [CODE_BITS-1:0] ch;
    } t_morse_entry;

    localparam t_morse_entry MORSE_TABLE [TABLE_LEN] = '{
        '{3'd2, 5'd2,  7'd65}, '{3'd4, 5'd1,  7'd66}, '{3'd4, 5'd5,  7'd67},
        '{3'd3, 5'd1,  7'd68}, '{3'd1, 5'd0,  7'd69}, '{3'd4, 5'd4,  7'd70},
        '{3'd3, 5'd3,  7'd71}, '{3'd4, 5'd0,  7'd72}, '{3'd2, 5'd0,  7'd73},
        '{3'd4, 5'd14, 7'd74}, '{3'd3, 5'd5,  7'd75}, '{3'd4, 5'd2,  7'd76},
        '{3'd2, 5'd3,  7'd77}, '{3'd2, 5'd1,  7'd78}, '{3'd3, 5'd7,  7'd79},
        '{3'd4, 5'd6,  7'd80}, '{3'd4, 5'd11, 7'd81}, '{3'd3, 5'd2,  7'd82},
        '{3'd3, 5'd0,  7'd83}, '{3'd1, 5'd1,  7'd84}, '{3'd3, 5'd4,  7'd85},
        '{3'd4, 5'd8,  7'd86}, '{3'd3, 5'd6,  7'd87}, '{3'd4, 5'd9,  7'd88},
        '{3'd4, 5'd13, 7'd89}, '{3'd4, 5'd3,  7'd90},
        '{3'd5, 5'd31, 7'd48}, '{3'd5, 5'd30, 7'd49}, '{3'd5, 5'd28, 7'd50},
        '{3'd5, 5'd24, 7'd51}, '{3'd5, 5'd16, 7'd52}, '{3'd5, 5'd0,  7'd53},
        '{3'd5, 5'd1,  7'd54}, '{3'd5, 5'd3,  7'd55}, '{3'd5, 5'd7,  7'd56},
        '{3'd5, 5'd15, 7'd57}
    };

    // Parallel compare against every table entry; 0 when nothing matches.
    function automatic logic [CODE_BITS-1:0] morse_lookup(
        input logic [CNT_BITS-1:0]    cnt,
        input logic [MAX_SYMBOLS-1:0] pat
    );
        logic [CODE_BITS-1:0] code;
        code = '0;
        for (int k = 0; k < TABLE_LEN; k++) begin
            if (cnt == CNT_BITS'(MORSE_TABLE[k].len) &&
                pat == MAX_SYMBOLS'(MORSE_TABLE[k].pat)) begin
                code = MORSE_TABLE[k].ch;
            end
        end
        return code;
    endfunction

endpackage

// File: rtl/mkd_if.sv
// ----------------------------------------------------------------------------
// mkd interfaces
// Valid/ready channels for key samples, results and register writes.
// ----------------------------------------------------------------------------
interface mkd_key_if;
    logic valid;
    logic ready;
    logic key_level;

    modport source (output valid, output key_level, input ready);
    modport sink   (input valid, input key_level, output ready);
endinterface

interface mkd_res_if import mkd_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic                 lamp_on;
    logic [1:0]           symbol_added;
    logic                 letter_ready;
    logic                 letter_invalid;
    logic [CODE_BITS-1:0] letter_code;

    modport source (output valid, output lamp_on, output symbol_added,
                    output letter_ready, output letter_invalid,
                    output letter_code, input ready);
    modport sink   (input valid, input lamp_on, input symbol_added,
                    input letter_ready, input letter_invalid,
                    input letter_code, output ready);
endinterface

interface mkd_cfg_if import mkd_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/morse_key_decoder_top.sv
// ----------------------------------------------------------------------------
// morse_key_decoder_top
// Straight-key Morse decoder: one key sample per tick in, one result per tick
// out (lamp, symbol appended, decided letter).
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+------------------------------------
//  i_key    | in  | valid/ready           | key_level
//  i_cfg    | in  | valid/ready (ready=1) | index, data (0 dash thr, 1 gap)
//  o_res    | out | valid/ready           | lamp_on, symbol_added,
//           |     |                       | letter_ready, letter_invalid,
//           |     |                       | letter_code
//
//  One transaction per clock sustained while o_res is ready; input register
//  to result register, with all timer and decode logic between them.
//  Reset (synchronous, active low) gives a released key, idle timer
//  saturated, empty store and default thresholds 200 / 500 ticks.
//  A stalled result holds the result register; the input register still
//  takes one more transaction, then i_key.ready drops until o_res drains.
//
module morse_key_decoder_top
    import mkd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mkd_key_if.sink    i_key,
    mkd_cfg_if.sink    i_cfg,
    mkd_res_if.source  o_res
);

    // configuration registers
    logic [CFG_DATA_BITS-1:0] r_dash_thr;
    logic [CFG_DATA_BITS-1:0] r_gap;

    // input register
    logic r_in_valid;
    logic r_in_key;

    // result register
    logic                 r_out_valid;
    logic                 r_out_lamp;
    t_sym                 r_out_sym;
    logic                 r_out_ready;
    logic                 r_out_invalid;
    logic [CODE_BITS-1:0] r_out_code;

    logic     step;   // input register moves into the result register
    t_key_evt evt;
    t_letter  letter;

    assign step        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_key.ready = !r_in_valid || step;
    assign i_cfg.ready = 1'b1;

    // register writes; the user must issue them only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dash_thr <= DASH_THR_RESET;
            r_gap      <= LETTER_GAP_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_DASH_THRESHOLD: r_dash_thr <= i_cfg.data;
                CFG_LETTER_GAP:     r_gap      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_key.ready) begin
            r_in_valid <= i_key.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key.valid && i_key.ready) begin
            r_in_key <= i_key.key_level;
        end
    end

    // key timing: state advances only when a transaction is processed
    mkd_key_timer u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (step),
        .i_key_level (r_in_key),
        .i_dash_thr  (r_dash_thr),
        .i_gap       (r_gap),
        .o_evt       (evt)
    );

    // symbol store and decode
    mkd_letter u_letter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step),
        .i_evt    (evt),
        .o_letter (letter)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= step || (r_out_valid && !o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_lamp    <= evt.held;
            r_out_sym     <= evt.sym;
            r_out_ready   <= letter.ready;
            r_out_invalid <= letter.invalid;
            r_out_code    <= letter.code;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.lamp_on        = r_out_lamp;
    assign o_res.symbol_added   = r_out_sym;
    assign o_res.letter_ready   = r_out_ready;
    assign o_res.letter_invalid = r_out_invalid;
    assign o_res.letter_code    = r_out_code;

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed transaction lost before result register");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_key.ready |-> (r_in_valid && r_out_valid && !o_res.ready))
        else $error("input back-pressure without a full pipeline");

endmodule

// File: rtl/mkd_key_timer.sv
// ----------------------------------------------------------------------------
// mkd_key_timer
// Key state, press and idle timers, dot/dash classification, gap detect.
// ----------------------------------------------------------------------------
module mkd_key_timer
    import mkd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_key_level,
    input  logic [CFG_DATA_BITS-1:0] i_dash_thr,
    input  logic [CFG_DATA_BITS-1:0] i_gap,
    output t_key_evt                 o_evt
);

    logic                  r_held;
    logic [TIMER_BITS-1:0] r_press;
    logic [TIMER_BITS-1:0] r_idle;
    logic                  n_held;
    logic [TIMER_BITS-1:0] n_press;
    logic [TIMER_BITS-1:0] n_idle;
    logic [TIMER_BITS-1:0] press_inc;
    logic [TIMER_BITS-1:0] idle_inc;
    t_sym                  sym;

    // saturating increments
    assign press_inc = (r_press == '1) ? r_press : r_press + 1'b1;
    assign idle_inc  = (r_idle == '1) ? r_idle : r_idle + 1'b1;

    always_comb begin
        n_held  = r_held;
        n_press = r_held ? press_inc : r_press;
        n_idle  = r_held ? r_idle : idle_inc;
        sym     = SYM_NONE;
        if (i_key_level && !r_held) begin
            n_held  = 1'b1;
            n_press = '0;
        end else if (!i_key_level && r_held) begin
            n_held = 1'b0;
            n_idle = '0;
            sym    = (CMP_BITS'(press_inc) >= CMP_BITS'(i_dash_thr)) ? SYM_DASH : SYM_DOT;
        end
    end

    assign o_evt.held    = n_held;
    assign o_evt.sym     = sym;
    assign o_evt.gap_hit = !n_held && (CMP_BITS'(n_idle) > CMP_BITS'(i_gap));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_press <= '0;
            r_idle  <= '1;
        end else if (i_en) begin
            r_held  <= n_held;
            r_press <= n_press;
            r_idle  <= n_idle;
        end
    end

    a_sym_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.sym != SYM_NONE) |-> (r_held && !i_key_level))
        else $error("symbol produced without a release");

    a_idle_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_evt.sym != SYM_NONE) |=> (r_idle == '0 && !r_held))
        else $error("idle timer not restarted on release");

endmodule

// File: rtl/mkd_letter.sv
// ----------------------------------------------------------------------------
// mkd_letter
// Symbol store with overflow flag and table decode at the letter gap.
// ----------------------------------------------------------------------------
module mkd_letter
    import mkd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_key_evt i_evt,
    output t_letter  o_letter
);

    logic [MAX_SYMBOLS-1:0] r_pat;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_ovf;
    logic [MAX_SYMBOLS-1:0] n_pat;
    logic [CNT_BITS-1:0]    n_cnt;
    logic                   n_ovf;
    logic [CODE_BITS-1:0]   code;
    logic                   ready;

    // append the symbol of this tick, if any
    always_comb begin
        n_pat = r_pat;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (i_evt.sym != SYM_NONE) begin
            if (r_cnt < CNT_BITS'(MAX_SYMBOLS)) begin
                if (i_evt.sym == SYM_DASH) begin
                    n_pat = r_pat | (MAX_SYMBOLS'(1) << r_cnt);
                end
                n_cnt = r_cnt + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    assign ready = i_evt.gap_hit && ((n_cnt != '0) || n_ovf);
    assign code  = n_ovf ? '0 : morse_lookup(n_cnt, n_pat);

    assign o_letter.ready   = ready;
    assign o_letter.invalid = ready && (code == '0);
    assign o_letter.code    = ready ? code : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_en) begin
            if (ready) begin
                r_pat <= '0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_pat <= n_pat;
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(MAX_SYMBOLS))
        else $error("symbol count beyond store depth");

    a_ovf_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_letter.ready && n_ovf) |-> o_letter.invalid)
        else $error("overflowed letter reported as valid");

endmodule
